// ===== rtl/core/mhp_pkg.sv =====
package mhp_pkg;

    // field widths of the three channels
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int ID_W      = 6;
    localparam int LEN_W     = 15;
    localparam int BODY_W    = 28;
    localparam int HSIZE_W   = 13;
    localparam int CTYPE_W   = 6;
    localparam int SUBTYPE_W = 9;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CORE_W    = 56;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DESC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // summary status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SCRAMBLED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COMPRESSED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERRUN    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_NAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCRAMBLED    = 2'd2;

    // configuration reset values
    localparam logic [ID_W-1:0] RST_CONTENT_NAME = 6'd12;
    localparam logic [ID_W-1:0] RST_COMPRESSION  = 6'd17;
    localparam logic [ID_W-1:0] RST_SCRAMBLED    = 6'd35;

    // header core length in bytes
    localparam logic [HSIZE_W-1:0] CORE_LEN = 13'd7;

    // parameter length indicator codes
    localparam logic [1:0] PLI_NONE  = 2'd0;
    localparam logic [1:0] PLI_ONE   = 2'd1;
    localparam logic [1:0] PLI_FOUR  = 2'd2;
    localparam logic [1:0] PLI_EXTRA = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ID_W-1:0]      param_id;
        logic                 param_class;
        logic [LEN_W-1:0]     param_len;
        logic [BYTE_W-1:0]    data_byte;
        logic [LEN_W-1:0]     data_index;
        logic [BODY_W-1:0]    body_size;
        logic [HSIZE_W-1:0]   header_size;
        logic [CTYPE_W-1:0]   content_type;
        logic [SUBTYPE_W-1:0] content_subtype;
        logic [STATUS_W-1:0]  status;
        logic                 end_of_run;
    } t_result;

endpackage

// ===== rtl/core/mhp_if.sv =====
// header byte channel
interface mhp_in_if;
    logic                         valid;
    logic                         ready;
    logic [mhp_pkg::BYTE_W-1:0]   hdr_byte;
    logic                         final_byte;

    modport source (output valid, hdr_byte, final_byte, input ready);
    modport sink   (input valid, hdr_byte, final_byte, output ready);
endinterface

// result channel
interface mhp_out_if;
    logic                            valid;
    logic                            ready;
    logic [mhp_pkg::KIND_W-1:0]      kind;
    logic [mhp_pkg::ID_W-1:0]        param_id;
    logic                            param_class;
    logic [mhp_pkg::LEN_W-1:0]       param_len;
    logic [mhp_pkg::BYTE_W-1:0]      data_byte;
    logic [mhp_pkg::LEN_W-1:0]       data_index;
    logic [mhp_pkg::BODY_W-1:0]      body_size;
    logic [mhp_pkg::HSIZE_W-1:0]     header_size;
    logic [mhp_pkg::CTYPE_W-1:0]     content_type;
    logic [mhp_pkg::SUBTYPE_W-1:0]   content_subtype;
    logic [mhp_pkg::STATUS_W-1:0]    status;
    logic                            end_of_run;

    modport source (output valid, kind, param_id, param_class, param_len, data_byte,
                    data_index, body_size, header_size, content_type, content_subtype,
                    status, end_of_run, input ready);
    modport sink   (input valid, kind, param_id, param_class, param_len, data_byte,
                    data_index, body_size, header_size, content_type, content_subtype,
                    status, end_of_run, output ready);
endinterface

// configuration write channel
interface mhp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mhp_pkg::CFG_IDX_W-1:0]   index;
    logic [mhp_pkg::ID_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mot_header_parser_core.sv =====
// MOT header parser. Header bytes enter one per cycle while ready is high; each
// accepted byte is parsed in the same cycle against the registered parse state
// and its results (a parameter descriptor or data byte, and the header summary
// on the final byte) go into a three-entry result queue that feeds the output
// channel. A steady stream of bytes that yield one result or none runs at one
// byte per cycle while the output is taken; a final byte that also yields a
// descriptor or a data byte gives two results and holds the input off while
// the queue drains. The input is taken while at most one result waits in the
// queue, so the input rate is set by the queue depth and the output rate.
// Configuration writes are always taken and need no idle cycles; no clearing
// pass follows reset.
module mot_header_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mhp_in_if.sink       i_in,
    mhp_out_if.source    o_out,
    mhp_cfg_if.sink      i_cfg
);

    localparam int QDEPTH = 3;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_CORE,
        PH_PHDR,
        PH_LEN1,
        PH_LEN2,
        PH_DATA,
        PH_SKIP,
        PH_DONE
    } t_phase;

    // configuration registers
    logic [mhp_pkg::ID_W-1:0] r_name_id, r_comp_id, r_scr_id;

    // parse state
    logic [mhp_pkg::HSIZE_W-1:0] r_byte_count, n_byte_count;
    logic [mhp_pkg::CORE_W-1:0]  r_core, n_core;
    t_phase                      r_phase, n_phase;
    logic [mhp_pkg::ID_W-1:0]    r_cur, n_cur;
    logic [6:0]                  r_len_high, n_len_high;
    logic [mhp_pkg::LEN_W-1:0]   r_left, n_left;
    logic [mhp_pkg::LEN_W-1:0]   r_offset, n_offset;
    logic [mhp_pkg::STATUS_W-1:0] r_err, n_err;

    // result queue
    mhp_pkg::t_result r_q [QDEPTH];
    mhp_pkg::t_result n_q [QDEPTH];
    logic [CNT_W-1:0] r_count, n_count;

    logic             acc, pop;
    logic [CNT_W-1:0] cnt_after, push_n;
    mhp_pkg::t_result prm, summ, res0, res1;
    logic             emit;

    logic [mhp_pkg::HSIZE_W-1:0] hs, hs_new, rem;
    logic                        open_req, ovr, skip;
    logic [mhp_pkg::LEN_W-1:0]   open_len;
    logic [1:0]                  pli;
    logic                        core_ok;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_count <= CNT_W'(1));
    assign acc         = i_in.valid && i_in.ready;
    assign pop         = o_out.valid && o_out.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_id <= mhp_pkg::RST_CONTENT_NAME;
            r_comp_id <= mhp_pkg::RST_COMPRESSION;
            r_scr_id  <= mhp_pkg::RST_SCRAMBLED;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                mhp_pkg::CFG_CONTENT_NAME: r_name_id <= i_cfg.data;
                mhp_pkg::CFG_COMPRESSION:  r_comp_id <= i_cfg.data;
                mhp_pkg::CFG_SCRAMBLED:    r_scr_id  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // parse one byte against the current state
    always_comb begin
        n_byte_count = r_byte_count;
        n_core       = r_core;
        n_phase      = r_phase;
        n_cur        = r_cur;
        n_len_high   = r_len_high;
        n_left       = r_left;
        n_offset     = r_offset;
        n_err        = r_err;
        emit         = 1'b0;
        prm          = '0;
        summ         = '0;
        open_req     = 1'b0;
        open_len     = '0;
        ovr          = 1'b0;
        skip         = 1'b0;
        rem          = '0;
        hs_new       = '0;
        core_ok      = 1'b0;
        pli          = i_in.hdr_byte[7:6];
        hs           = r_core[27:15];

        if (acc) begin
            if (r_phase == PH_CORE) begin
                // shift in the header core
                n_core       = {r_core[mhp_pkg::CORE_W-9:0], i_in.hdr_byte};
                n_byte_count = r_byte_count + 1'b1;
                if (n_byte_count == mhp_pkg::CORE_LEN) begin
                    hs_new = n_core[27:15];
                    if (hs_new < mhp_pkg::CORE_LEN) begin
                        n_err   = mhp_pkg::ST_MISMATCH;
                        n_phase = PH_DONE;
                    end else if (hs_new == mhp_pkg::CORE_LEN) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_PHDR;
                    end
                end
            end else if (r_byte_count >= hs) begin
                // byte past the declared header size
                n_err   = mhp_pkg::ST_MISMATCH;
                n_phase = PH_DONE;
            end else begin
                n_byte_count = r_byte_count + 1'b1;
                rem          = hs - n_byte_count;
                case (r_phase)
                    PH_PHDR: begin
                        n_cur = i_in.hdr_byte[5:0];
                        if (pli == mhp_pkg::PLI_EXTRA) begin
                            if (rem == '0) ovr = 1'b1;
                            else n_phase = PH_LEN1;
                        end else begin
                            open_req = 1'b1;
                            case (pli)
                                mhp_pkg::PLI_NONE: open_len = 15'd0;
                                mhp_pkg::PLI_ONE:  open_len = 15'd1;
                                mhp_pkg::PLI_FOUR: open_len = 15'd4;
                                default:           open_len = 15'd0;
                            endcase
                        end
                    end
                    PH_LEN1: begin
                        if (i_in.hdr_byte[7]) begin
                            if (rem == '0) begin
                                ovr = 1'b1;
                            end else begin
                                n_len_high = i_in.hdr_byte[6:0];
                                n_phase    = PH_LEN2;
                            end
                        end else begin
                            open_req = 1'b1;
                            open_len = {8'd0, i_in.hdr_byte[6:0]};
                        end
                    end
                    PH_LEN2: begin
                        open_req = 1'b1;
                        open_len = {r_len_high, i_in.hdr_byte};
                    end
                    PH_DATA: begin
                        emit            = 1'b1;
                        prm.kind        = mhp_pkg::KIND_DATA;
                        prm.param_id    = r_cur;
                        prm.param_class = (r_cur == r_name_id);
                        prm.param_len   = r_offset + r_left;
                        prm.data_byte   = i_in.hdr_byte;
                        prm.data_index  = r_offset;
                        n_offset        = r_offset + 1'b1;
                        n_left          = r_left - 1'b1;
                        if (n_left == '0) n_phase = (rem == '0) ? PH_DONE : PH_PHDR;
                    end
                    PH_SKIP: begin
                        n_left = r_left - 1'b1;
                        if (n_left == '0) n_phase = (rem == '0) ? PH_DONE : PH_PHDR;
                    end
                    default: ;
                endcase

                // open a parameter once its length is known
                if (open_req) begin
                    if (open_len > {2'b00, rem}) begin
                        ovr = 1'b1;
                    end else begin
                        if (n_cur != r_name_id) begin
                            if (n_cur == r_scr_id) begin
                                skip = 1'b1;
                                if (r_err == mhp_pkg::ST_OK) n_err = mhp_pkg::ST_SCRAMBLED;
                            end else if (n_cur == r_comp_id) begin
                                skip = 1'b1;
                                if (r_err == mhp_pkg::ST_OK) n_err = mhp_pkg::ST_COMPRESSED;
                            end
                        end
                        if (!skip) begin
                            emit            = 1'b1;
                            prm.kind        = mhp_pkg::KIND_DESC;
                            prm.param_id    = n_cur;
                            prm.param_class = (n_cur == r_name_id);
                            prm.param_len   = open_len;
                        end
                        if (open_len == '0) begin
                            n_phase = (rem == '0) ? PH_DONE : PH_PHDR;
                        end else begin
                            n_left  = open_len;
                            n_phase = skip ? PH_SKIP : PH_DATA;
                            if (!skip) n_offset = '0;
                        end
                    end
                end

                // field runs past the header: ignore the rest
                if (ovr) begin
                    if (r_err == mhp_pkg::ST_OK) n_err = mhp_pkg::ST_OVERRUN;
                    n_phase = PH_DONE;
                end
            end

            prm.end_of_run = !i_in.final_byte;

            // summary on the final byte, then back to the start
            if (i_in.final_byte) begin
                core_ok           = (n_phase != PH_CORE);
                summ.kind         = mhp_pkg::KIND_SUMMARY;
                summ.end_of_run   = 1'b1;
                if (!core_ok) summ.status = mhp_pkg::ST_TOO_SHORT;
                else if (n_err != mhp_pkg::ST_OK) summ.status = n_err;
                else if (n_phase != PH_DONE) summ.status = mhp_pkg::ST_OVERRUN;
                else summ.status = mhp_pkg::ST_OK;
                if (core_ok) begin
                    summ.body_size       = n_core[55:28];
                    summ.header_size     = n_core[27:15];
                    summ.content_type    = n_core[14:9];
                    summ.content_subtype = n_core[8:0];
                end
                n_byte_count = '0;
                n_core       = '0;
                n_phase      = PH_CORE;
                n_cur        = '0;
                n_len_high   = '0;
                n_left       = '0;
                n_offset     = '0;
                n_err        = mhp_pkg::ST_OK;
            end
        end
    end

    // results pushed this cycle
    assign push_n = (acc && emit ? CNT_W'(1) : CNT_W'(0))
                  + (acc && i_in.final_byte ? CNT_W'(1) : CNT_W'(0));
    assign res0   = emit ? prm : summ;
    assign res1   = summ;

    // result queue: shift out at the head, append behind the last entry
    assign cnt_after = r_count - (pop ? CNT_W'(1) : CNT_W'(0));
    assign n_count   = cnt_after + push_n;

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) n_q[i] = r_q[i + 1];
            else n_q[i] = r_q[i];
            if (push_n != '0 && CNT_W'(i) == cnt_after) n_q[i] = res0;
            if (push_n == CNT_W'(2) && CNT_W'(i) == cnt_after + 1'b1) n_q[i] = res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_core       <= '0;
            r_phase      <= PH_CORE;
            r_cur        <= '0;
            r_len_high   <= '0;
            r_left       <= '0;
            r_offset     <= '0;
            r_err        <= mhp_pkg::ST_OK;
            r_count      <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_core       <= n_core;
            r_phase      <= n_phase;
            r_cur        <= n_cur;
            r_len_high   <= n_len_high;
            r_left       <= n_left;
            r_offset     <= n_offset;
            r_err        <= n_err;
            r_count      <= n_count;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // output channel from the queue head
    assign o_out.valid           = (r_count != '0);
    assign o_out.kind            = r_q[0].kind;
    assign o_out.param_id        = r_q[0].param_id;
    assign o_out.param_class     = r_q[0].param_class;
    assign o_out.param_len       = r_q[0].param_len;
    assign o_out.data_byte       = r_q[0].data_byte;
    assign o_out.data_index      = r_q[0].data_index;
    assign o_out.body_size       = r_q[0].body_size;
    assign o_out.header_size     = r_q[0].header_size;
    assign o_out.content_type    = r_q[0].content_type;
    assign o_out.content_subtype = r_q[0].content_subtype;
    assign o_out.status          = r_q[0].status;
    assign o_out.end_of_run      = r_q[0].end_of_run;

`ifndef ASSERT_OFF
    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("result queue overfilled");

    // final byte returns the parser to the start
    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.final_byte) |=> (r_phase == PH_CORE && r_byte_count == '0))
        else $error("parser not restarted after final byte");

    // a data phase always has bytes outstanding
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_SKIP) |-> (r_left != '0))
        else $error("data phase with no bytes left");

    // the summary is always the last result of its byte
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == mhp_pkg::KIND_SUMMARY) |-> o_out.end_of_run)
        else $error("summary without end of run");

    // core collection stops at the core length
    a_core_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CORE) |-> (r_byte_count < mhp_pkg::CORE_LEN))
        else $error("core byte count past core length");
`endif

endmodule
